// ===== design/vp8rtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8rtp_pkg
// Shared types and constants of the VP8 RTP packetizer.
// ----------------------------------------------------------------------------
package vp8rtp_pkg;

    localparam int FRAME_LEN_BITS = 24;
    localparam int CMP_W = (FRAME_LEN_BITS > 11) ? FRAME_LEN_BITS : 11;
    localparam int HEADER_BYTES = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] VP8_START_BYTE = 8'h10;
    localparam logic [6:0] TS_DIVISOR = 7'd100;
    localparam logic [15:0] TS_RECIP = 16'd41944;
    localparam int TS_RECIP_SHIFT = 22;

    localparam logic [10:0] RST_MAX_PACKET = 11'd1400;
    localparam logic [6:0] RST_PAYLOAD_TYPE = 7'd96;
    localparam logic [31:0] RST_STREAM_ID = 32'hdeadbeef;

    localparam logic [1:0] REG_MAX_PACKET = 2'd0;
    localparam logic [1:0] REG_MEDIA_START = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd2;
    localparam logic [1:0] REG_STREAM_ID = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [7:0]                data_byte;
        logic [FRAME_LEN_BITS-1:0] frame_length;
        logic signed [63:0]        time_us;
    } vp8rtp_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_datagram;
    } vp8rtp_result_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        open;
        logic        marker;
        logic        start_bit;
        logic        last;
        logic [31:0] ts;
    } vp8rtp_entry_t;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] stream_id;
    } vp8rtp_hdr_cfg_t;

endpackage

// ===== design/vp8rtp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8rtp_front
// Accepts commands, tracks frame and chunk state, computes the RTP timestamp.
// ----------------------------------------------------------------------------
module vp8rtp_front
    import vp8rtp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  vp8rtp_item_t        item,
    input  logic [10:0]         max_packet_bytes,
    input  logic signed [63:0]  media_start_us,
    output logic                q_push,
    output vp8rtp_entry_t       q_entry,
    input  logic                q_full
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic [63:0]               work_reg, work_next;
    logic [6:0]                rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic [31:0]               ts_reg, ts_next;
    logic [FRAME_LEN_BITS-1:0] frame_left_reg, frame_left_next;
    logic [10:0]               chunk_left_reg, chunk_left_next;
    logic                      first_reg, first_next;

    logic              accept;
    logic [10:0]       cap;
    logic [CMP_W-1:0]  frame_ext;
    logic              open;
    logic              marker;
    logic [10:0]       copy;
    logic [10:0]       chunk_cur;
    logic [10:0]       chunk_after;
    logic [14:0]       div_v;
    logic [30:0]       div_prod;
    logic [7:0]        div_q;
    logic [14:0]       div_back;

    assign full   = (state_reg != S_IDLE) || q_full;
    assign accept = push && !full;

    assign cap       = (max_packet_bytes > 11'(HEADER_BYTES))
                     ? max_packet_bytes - 11'(HEADER_BYTES) : 11'd1;
    assign frame_ext = CMP_W'(frame_left_reg);
    assign open      = (chunk_left_reg == 11'd0);
    assign marker    = frame_ext <= CMP_W'(cap);
    assign copy      = marker ? 11'(frame_ext) : cap;
    assign chunk_cur = open ? copy : chunk_left_reg;
    assign chunk_after = chunk_cur - 11'd1;

    // one quotient byte per step by reciprocal multiplication
    assign div_v    = {rem_reg, work_reg[63:56]};
    assign div_prod = {16'd0, div_v} * {15'd0, TS_RECIP};
    assign div_q    = div_prod[TS_RECIP_SHIFT +: 8];
    assign div_back = 15'(div_q) * 15'(TS_DIVISOR);

    assign q_push = accept && (item.command == CMD_DATA)
                  && (frame_left_reg != '0);

    always_comb
    begin
        q_entry.data_byte = item.data_byte;
        q_entry.open      = open;
        q_entry.marker    = marker;
        q_entry.start_bit = first_reg;
        q_entry.last      = (chunk_after == 11'd0);
        q_entry.ts        = ts_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        ts_next         = ts_reg;
        frame_left_next = frame_left_reg;
        chunk_left_next = chunk_left_reg;
        first_next      = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.command == CMD_START))
                begin
                    frame_left_next = item.frame_length;
                    chunk_left_next = 11'd0;
                    first_next      = 1'b1;
                    work_next       = 64'(item.time_us - media_start_us);
                    state_next      = S_MUL;
                end
                else if (q_push)
                begin
                    frame_left_next = frame_left_reg - FRAME_LEN_BITS'(1);
                    chunk_left_next = chunk_after;
                    if (open)
                    begin
                        first_next = 1'b0;
                    end
                end
            end
            S_MUL:
            begin
                work_next  = (work_reg << 3) + work_reg;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next   = work_reg[63];
                work_next  = work_reg[63] ? 64'd0 - work_reg : work_reg;
                rem_next   = 7'd0;
                cnt_next   = 3'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = 7'(div_v - div_back);
                work_next = {work_reg[55:0], div_q};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ts_next    = neg_reg ? 32'd0 - work_reg[31:0] : work_reg[31:0];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= 3'd0;
            ts_reg         <= 32'd0;
            frame_left_reg <= '0;
            chunk_left_reg <= 11'd0;
            first_reg      <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ts_reg         <= ts_next;
            frame_left_reg <= frame_left_next;
            chunk_left_reg <= chunk_left_next;
            first_reg      <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
    end

endmodule

// ===== design/vp8rtp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8rtp_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module vp8rtp_queue
    import vp8rtp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_push,
    input  vp8rtp_entry_t q_entry,
    output logic          q_full,
    output logic          q_valid,
    output vp8rtp_entry_t q_head,
    input  logic          q_pop
);

    vp8rtp_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_entry;
        end
    end

endmodule

// ===== design/vp8rtp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8rtp_back
// Emits header bytes ahead of each chunk and the payload bytes after them.
// ----------------------------------------------------------------------------
module vp8rtp_back
    import vp8rtp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  vp8rtp_entry_t   q_head,
    output logic            q_pop,
    input  vp8rtp_hdr_cfg_t hdr_cfg,
    output logic            empty,
    input  logic            pop,
    output vp8rtp_result_t  result
);

    localparam logic [3:0] HB_VERSION = 4'd0;
    localparam logic [3:0] HB_TYPE    = 4'd1;
    localparam logic [3:0] HB_SEQ_HI  = 4'd2;
    localparam logic [3:0] HB_SEQ_LO  = 4'd3;
    localparam logic [3:0] HB_TS_3    = 4'd4;
    localparam logic [3:0] HB_TS_2    = 4'd5;
    localparam logic [3:0] HB_TS_1    = 4'd6;
    localparam logic [3:0] HB_TS_0    = 4'd7;
    localparam logic [3:0] HB_SSRC_3  = 4'd8;
    localparam logic [3:0] HB_SSRC_2  = 4'd9;
    localparam logic [3:0] HB_SSRC_1  = 4'd10;
    localparam logic [3:0] HB_SSRC_0  = 4'd11;
    localparam logic [3:0] HB_DESC    = 4'd12;

    logic [3:0]     idx_reg, idx_next;
    logic           res_valid_reg, res_valid_next;
    vp8rtp_result_t res_reg, res_next;
    logic           load;
    logic           in_hdr;
    logic [7:0]     hdr_byte;

    assign in_hdr = q_head.open && (idx_reg < 4'(HEADER_BYTES));
    assign load   = q_valid && (!res_valid_reg || pop);
    assign q_pop  = load && !in_hdr;
    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        case (idx_reg)
            HB_VERSION: hdr_byte = RTP_VERSION_BYTE;
            HB_TYPE:    hdr_byte = {q_head.marker, hdr_cfg.payload_type};
            HB_SEQ_HI:  hdr_byte = 8'h00;
            HB_SEQ_LO:  hdr_byte = 8'h00;
            HB_TS_3:    hdr_byte = q_head.ts[31:24];
            HB_TS_2:    hdr_byte = q_head.ts[23:16];
            HB_TS_1:    hdr_byte = q_head.ts[15:8];
            HB_TS_0:    hdr_byte = q_head.ts[7:0];
            HB_SSRC_3:  hdr_byte = hdr_cfg.stream_id[31:24];
            HB_SSRC_2:  hdr_byte = hdr_cfg.stream_id[23:16];
            HB_SSRC_1:  hdr_byte = hdr_cfg.stream_id[15:8];
            HB_SSRC_0:  hdr_byte = hdr_cfg.stream_id[7:0];
            HB_DESC:    hdr_byte = q_head.start_bit ? VP8_START_BYTE : 8'h00;
            default:    hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
            if (in_hdr)
            begin
                res_next.out_byte        = hdr_byte;
                res_next.end_of_datagram = 1'b0;
                idx_next                 = idx_reg + 4'd1;
            end
            else
            begin
                res_next.out_byte        = q_head.data_byte;
                res_next.end_of_datagram = q_head.last;
                idx_next                 = 4'd0;
            end
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== design/vp8_rtp_packetizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8_rtp_packetizer_top
// Splits an encoded VP8 frame into RTP datagrams, one byte per transaction.
//
// Input channel: push/full. A start transaction (command 0) gives the frame
// length and capture time; data transactions (command 1) carry frame bytes.
// Result channel: empty/pop, one datagram byte per transaction, with the
// last byte of each datagram flagged.
// A data byte that continues a datagram is written into the internal queue
// and then into the output register before it shows on the result ports.
// Payload bytes run at one per cycle while the receiver keeps up; each
// datagram adds 13 header bytes, during which the short internal queue
// absorbs incoming bytes until full rises. A start transaction holds
// full high while the timestamp is formed; the divide by 100 takes eight
// byte-wide reciprocal steps. When the receiver stalls, the output register
// holds its byte, the queue fills and full goes high; nothing is lost.
// Reset clears the frame state and loads the register defaults. Registers
// sit on an APB port at byte addresses 0, 8, 16 and 24, 64-bit data.
// ----------------------------------------------------------------------------
module vp8_rtp_packetizer_top
    import vp8rtp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    input  logic           push,
    output logic           full,
    input  vp8rtp_item_t   item,
    output logic           empty,
    input  logic           pop,
    output vp8rtp_result_t result
);

    logic [10:0]        max_packet_reg;
    logic signed [63:0] media_start_reg;
    logic [6:0]         payload_type_reg;
    logic [31:0]        stream_id_reg;

    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               q_push;
    vp8rtp_entry_t      q_entry;
    logic               q_full;
    logic               q_valid;
    vp8rtp_entry_t      q_head;
    logic               q_pop;
    vp8rtp_hdr_cfg_t    hdr_cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_PACKET:   prdata = {53'd0, max_packet_reg};
            REG_MEDIA_START:  prdata = media_start_reg;
            REG_PAYLOAD_TYPE: prdata = {57'd0, payload_type_reg};
            REG_STREAM_ID:    prdata = {32'd0, stream_id_reg};
            default:          prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_reg   <= RST_MAX_PACKET;
            media_start_reg  <= 64'sd0;
            payload_type_reg <= RST_PAYLOAD_TYPE;
            stream_id_reg    <= RST_STREAM_ID;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAX_PACKET:   max_packet_reg   <= pwdata[10:0];
                REG_MEDIA_START:  media_start_reg  <= pwdata;
                REG_PAYLOAD_TYPE: payload_type_reg <= pwdata[6:0];
                REG_STREAM_ID:    stream_id_reg    <= pwdata[31:0];
                default:          ;
            endcase
        end
    end

    assign hdr_cfg.payload_type = payload_type_reg;
    assign hdr_cfg.stream_id    = stream_id_reg;

    vp8rtp_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .item             (item),
        .max_packet_bytes (max_packet_reg),
        .media_start_us   (media_start_reg),
        .q_push           (q_push),
        .q_entry          (q_entry),
        .q_full           (q_full)
    );

    vp8rtp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    vp8rtp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .hdr_cfg (hdr_cfg),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the VP8 RTP packetizer byte by byte against a cycle-free model.
//
// A short directed table covers surplus bytes, empty frames, restarts in
// mid-frame, extreme lengths and times, and packet sizes below the header
// size. Random frames follow under several register settings, most of them
// well formed, some cut short or noisy. Both sides idle at random, with one
// phase that runs at full rate. Register writes happen only when the block
// is idle and are read back.
// ----------------------------------------------------------------------------
module testbench;
    import vp8rtp_pkg::*;

    localparam int START_BUSY_CYCLES = 80;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 20;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        logic [1:0]     cfg_sel;
        row_kind_t      kind;
        vp8rtp_result_t res;
        vp8rtp_item_t   stim;
    } row_t;

    typedef struct packed {
        logic [10:0] max_pkt;
        logic [63:0] media;
        logic [6:0]  pt;
        logic [31:0] ssrc;
    } cfg_t;

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [4:0]     paddr;
    logic [63:0]    pwdata;
    logic [63:0]    prdata;
    logic           pready;
    logic           push;
    logic           full;
    vp8rtp_item_t   item;
    logic           empty;
    logic           pop;
    vp8rtp_result_t result;

    bit steady;
    bit pop_hold;
    int mismatches;
    int stall_cycles;

    // model of the packetizer
    logic [10:0]        cfg_max_packet;
    logic signed [63:0] cfg_media_start;
    logic [6:0]         cfg_pt;
    logic [31:0]        cfg_ssrc;
    logic [23:0]        pk_frame_left;
    logic [10:0]        pk_chunk_left;
    logic               pk_first_chunk;
    logic [31:0]        pk_rtp_ts;

    vp8rtp_result_t step_bytes[$];
    vp8rtp_result_t datagram_bytes[$];
    row_t           dir_rows[$];
    cfg_t           dir_cfgs[3];

    vp8_rtp_packetizer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
    begin
        pop_hold = !steady && ($urandom_range(99) < 8);
    end

    assign pop = !pop_hold;

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s expected %0h got %0h at %0t", what, want, got, $realtime);
        end
    endtask

    function automatic void emit(input logic [7:0] b, input logic e);
        step_bytes.push_back({b, e});
    endfunction

    function automatic void packetize(input vp8rtp_item_t it);
        logic signed [63:0] t;
        logic signed [63:0] scaled;
        logic signed [63:0] quot;
        logic [10:0]        cap;
        logic [23:0]        copy;
        step_bytes.delete();
        if (it.command == CMD_START)
        begin
            t = it.time_us;
            scaled = (t - cfg_media_start) * 64'sd9;
            quot = scaled / 64'sd100;
            pk_rtp_ts = quot[31:0];
            pk_frame_left = it.frame_length;
            pk_chunk_left = '0;
            pk_first_chunk = 1'b1;
        end
        else if (pk_frame_left != '0)
        begin
            if (pk_chunk_left == '0)
            begin
                cap = (cfg_max_packet > 11'(HEADER_BYTES))
                    ? cfg_max_packet - 11'(HEADER_BYTES) : 11'd1;
                copy = (pk_frame_left < {13'd0, cap}) ? pk_frame_left : {13'd0, cap};
                emit(RTP_VERSION_BYTE, 1'b0);
                emit({copy == pk_frame_left, cfg_pt}, 1'b0);
                emit(8'h00, 1'b0);
                emit(8'h00, 1'b0);
                for (int k = 3; k >= 0; k--)
                begin
                    emit(pk_rtp_ts[k*8 +: 8], 1'b0);
                end
                for (int k = 3; k >= 0; k--)
                begin
                    emit(cfg_ssrc[k*8 +: 8], 1'b0);
                end
                emit(pk_first_chunk ? VP8_START_BYTE : 8'h00, 1'b0);
                pk_first_chunk = 1'b0;
                pk_chunk_left = copy[10:0];
            end
            pk_chunk_left--;
            pk_frame_left--;
            emit(it.data_byte, pk_chunk_left == '0);
        end
    endfunction

    function automatic vp8rtp_item_t rand_item(input logic cmd);
        vp8rtp_item_t it;
        it.command = cmd;
        it.data_byte = 8'($urandom);
        it.frame_length = 24'($urandom);
        it.time_us = {$urandom, $urandom};
        return it;
    endfunction

    function automatic vp8rtp_item_t start_cmd(input logic [23:0] len, input logic [63:0] t);
        vp8rtp_item_t it;
        it = rand_item(CMD_START);
        it.frame_length = len;
        it.time_us = t;
        return it;
    endfunction

    function automatic vp8rtp_item_t data_cmd(input logic [7:0] b);
        vp8rtp_item_t it;
        it = rand_item(CMD_DATA);
        it.data_byte = b;
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] sel, input row_kind_t kind,
                                    input logic [7:0] b, input logic e,
                                    input vp8rtp_item_t it);
        row_t r;
        r.cfg_sel = sel;
        r.kind = kind;
        r.res = {b, e};
        r.stim = it;
        dir_rows.push_back(r);
    endfunction

    task automatic send_row(input row_t r);
        while (!steady && $urandom_range(99) < 8)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        item = r.stim;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        packetize(r.stim);
        case (r.kind)
            ROW_MODEL:
            begin
                foreach (step_bytes[i])
                begin
                    datagram_bytes.push_back(step_bytes[i]);
                end
            end
            ROW_BYTE:
            begin
                datagram_bytes.push_back(r.res);
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    task automatic send_random(input logic cmd, input logic [23:0] len, input logic [63:0] t);
        row_t r;
        r.cfg_sel = '0;
        r.kind = ROW_MODEL;
        r.res = '0;
        r.stim = rand_item(cmd);
        if (cmd == CMD_START)
        begin
            r.stim.frame_length = len;
            r.stim.time_us = t;
        end
        send_row(r);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] want;
        case (idx)
            REG_MAX_PACKET:
            begin
                cfg_max_packet = val[10:0];
                want = {53'd0, val[10:0]};
            end
            REG_MEDIA_START:
            begin
                cfg_media_start = val;
                want = val;
            end
            REG_PAYLOAD_TYPE:
            begin
                cfg_pt = val[6:0];
                want = {57'd0, val[6:0]};
            end
            default:
            begin
                cfg_ssrc = val[31:0];
                want = {32'd0, val[31:0]};
            end
        endcase
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== want)
        begin
            flag_mismatch("register readback", want, prdata);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        push = 1'b0;
        while (datagram_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (START_BUSY_CYCLES) @(negedge clk);
        program_reg(REG_MAX_PACKET, {53'd0, c.max_pkt});
        program_reg(REG_MEDIA_START, c.media);
        program_reg(REG_PAYLOAD_TYPE, {57'd0, c.pt});
        program_reg(REG_STREAM_ID, {32'd0, c.ssrc});
    endtask

    always @(posedge clk)
    begin
        vp8rtp_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (datagram_bytes.size() == 0)
            begin
                flag_mismatch("result with nothing expected", 64'd0, {55'd0, result});
            end
            else
            begin
                want = datagram_bytes.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    flag_mismatch("out_byte", 64'(want.out_byte), 64'(result.out_byte));
                end
                if (result.end_of_datagram !== want.end_of_datagram)
                begin
                    flag_mismatch("end_of_datagram", 64'(want.end_of_datagram),
                                  64'(result.end_of_datagram));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_t        c;
        logic [1:0]  cur_sel;
        int          kind;
        int          len;
        int          n_data;
        int          sent;

        rst_n = 1'b0;
        push = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item = '0;
        steady = 1'b0;
        mismatches = 0;

        cfg_max_packet = RST_MAX_PACKET;
        cfg_media_start = '0;
        cfg_pt = RST_PAYLOAD_TYPE;
        cfg_ssrc = RST_STREAM_ID;
        pk_frame_left = '0;
        pk_chunk_left = '0;
        pk_first_chunk = 1'b1;
        pk_rtp_ts = '0;

        dir_cfgs[0] = {RST_MAX_PACKET, 64'd0, RST_PAYLOAD_TYPE, RST_STREAM_ID};
        dir_cfgs[1] = {11'd14, 64'h8000_0000_0000_0000, 7'd127, 32'h0000_0000};
        dir_cfgs[2] = {11'd0, 64'h7fff_ffff_ffff_ffff, 7'd0, 32'hffff_ffff};

        // reset settings: surplus bytes, empty frame, restarts, extreme values
        add_row(0, ROW_NONE, 8'h00, 1'b0, data_cmd(8'h55));
        add_row(0, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd0, 64'd0));
        add_row(0, ROW_NONE, 8'h00, 1'b0, data_cmd(8'h00));
        add_row(0, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd3, 64'h7fff_ffff_ffff_ffff));
        add_row(0, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'hff));
        add_row(0, ROW_BYTE, 8'h00, 1'b0, data_cmd(8'h00));
        add_row(0, ROW_BYTE, 8'ha5, 1'b1, data_cmd(8'ha5));
        add_row(0, ROW_NONE, 8'h00, 1'b0, data_cmd(8'h5a));
        add_row(0, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd5, 64'h8000_0000_0000_0000));
        add_row(0, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'h01));
        add_row(0, ROW_BYTE, 8'h02, 1'b0, data_cmd(8'h02));
        add_row(0, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd2, 64'hffff_ffff_ffff_ffff));
        add_row(0, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'h80));
        add_row(0, ROW_BYTE, 8'h7f, 1'b1, data_cmd(8'h7f));
        add_row(0, ROW_NONE, 8'h00, 1'b0, start_cmd(24'hff_ffff, 64'd12345));
        add_row(0, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'hc3));
        add_row(0, ROW_BYTE, 8'h3c, 1'b0, data_cmd(8'h3c));
        // one payload byte per datagram, wrapped time difference
        add_row(1, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd3, 64'd0));
        add_row(1, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'h00));
        add_row(1, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'hff));
        add_row(1, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'haa));
        // packet size below the header size
        add_row(2, ROW_NONE, 8'h00, 1'b0, start_cmd(24'd2, 64'h8000_0000_0000_0000));
        add_row(2, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'h11));
        add_row(2, ROW_MODEL, 8'h00, 1'b0, data_cmd(8'h22));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        cur_sel = 2'd0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_sel != cur_sel)
            begin
                cur_sel = dir_rows[i].cfg_sel;
                apply_config(dir_cfgs[cur_sel]);
            end
            send_row(dir_rows[i]);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                c.max_pkt = 11'd2047;
            end
            else if (ph == 2)
            begin
                c.max_pkt = 11'($urandom_range(13, 0));
            end
            else
            begin
                c.max_pkt = 11'($urandom_range(60, 14));
            end
            c.media = {$urandom, $urandom};
            c.pt = 7'($urandom_range(127, 0));
            c.ssrc = $urandom;
            apply_config(c);
            steady = (ph == 1);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 82)
                begin
                    len = (kind < 4) ? 0 : $urandom_range(30, 1);
                    n_data = len + ((kind % 10 == 0) ? $urandom_range(3, 1) : 0);
                end
                else if (kind < 92)
                begin
                    len = $urandom_range(30, 2);
                    n_data = $urandom_range(len - 1, 1);
                end
                else
                begin
                    len = $urandom_range(24'hff_ffff, 0);
                    n_data = $urandom_range(5, 1);
                end
                send_random(CMD_START, 24'(len), {$urandom, $urandom});
                repeat (n_data) send_random(CMD_DATA, '0, '0);
                sent += 1 + n_data;
            end
        end
        steady = 1'b0;
        push = 1'b0;

        while (datagram_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (START_BUSY_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
